// File: rtl/crdp_pkg.sv
// crdp_pkg: shared types, widths and codes for the capped descriptor ring
// used by crdp_ctrl, crdp_datapath and the top level; no dependencies
package crdp_pkg;

   localparam int DEPTH  = 1024;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = 11;
   localparam int LEN_W  = 16;
   localparam int BYTE_W = 24;
   localparam int TAG_W  = 64;
   localparam int STS_W  = 3;
   localparam int DROP_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;

   // request kinds
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // result status codes
   localparam logic [STS_W-1:0] STS_STORED         = 3'd0;
   localparam logic [STS_W-1:0] STS_EVICTED_STORED = 3'd1;
   localparam logic [STS_W-1:0] STS_DROPPED        = 3'd2;
   localparam logic [STS_W-1:0] STS_POPPED         = 3'd3;
   localparam logic [STS_W-1:0] STS_EMPTY          = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_NEWEST = 2'd2;

   // configuration reset values
   localparam logic [CNT_W-1:0]  MAX_ENTRIES_RST = 11'd1024;
   localparam logic [BYTE_W-1:0] MAX_BYTES_RST   = 24'd1048576;

   typedef struct packed {
      logic              req_type;
      logic [LEN_W-1:0]  item_length;
      logic [TAG_W-1:0]  item_tag;
   } req_item_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [LEN_W-1:0]  out_length;
      logic [TAG_W-1:0]  out_tag;
      logic [CNT_W-1:0]  evicted_count;
      logic [DROP_W-1:0] drop_total;
      logic [CNT_W-1:0]  occupancy;
      logic [BYTE_W-1:0] bytes_held;
      logic [CNT_W-1:0]  peak_entries;
      logic [BYTE_W-1:0] peak_bytes;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic             latch;
      logic             evict;
      logic             pop;
      logic             store;
      logic             drop;
      logic             finish;
      logic [STS_W-1:0] status;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pop;
      logic empty;
      logic full;
      logic over;
      logic oversize;
      logic newest_mode;
      logic evicted_any;
   } dp_stat_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

// File: rtl/crdp_ctrl.sv
// crdp_ctrl: sequencing state machine for the descriptor ring
// depends on crdp_pkg; drives crdp_datapath through ctl_cmd_type
module crdp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  crdp_pkg::dp_stat_type stat,
   output crdp_pkg::ctl_cmd_type cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_CHECK = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.status = crdp_pkg::STS_STORED;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.is_pop) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
               if (stat.empty) begin
                  cmd.status = crdp_pkg::STS_EMPTY;
               end else begin
                  cmd.pop    = 1'b1;
                  cmd.status = crdp_pkg::STS_POPPED;
               end
            end else if (stat.oversize) begin
               cmd.drop   = 1'b1;
               cmd.finish = 1'b1;
               cmd.status = crdp_pkg::STS_DROPPED;
               state_in   = ST_IDLE;
            end else if (stat.newest_mode) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
               if (stat.full || (!stat.empty && stat.over)) begin
                  cmd.drop   = 1'b1;
                  cmd.status = crdp_pkg::STS_DROPPED;
               end else begin
                  cmd.store  = 1'b1;
                  cmd.status = crdp_pkg::STS_STORED;
               end
            end else if (!stat.empty && (stat.full || stat.over)) begin
               // evict one head entry, then check again
               cmd.evict = 1'b1;
            end else begin
               cmd.store  = 1'b1;
               cmd.finish = 1'b1;
               cmd.status = stat.evicted_any ? crdp_pkg::STS_EVICTED_STORED
                                             : crdp_pkg::STS_STORED;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign busy      = (state_ff == ST_CHECK);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/crdp_datapath.sv
// crdp_datapath: descriptor memories, pointers, counters, caps and result register
// depends on crdp_pkg; steered by crdp_ctrl
module crdp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [crdp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crdp_pkg::CSR_DAT_W-1:0]      csr_data,
   input  crdp_pkg::req_item_type              req_item,
   input  crdp_pkg::ctl_cmd_type               cmd,
   output crdp_pkg::dp_stat_type               stat,
   output crdp_pkg::rsp_item_type              rsp_item
);

   // descriptor memories
   logic [crdp_pkg::LEN_W-1:0] length_mem [crdp_pkg::DEPTH];
   logic [crdp_pkg::TAG_W-1:0] tag_mem    [crdp_pkg::DEPTH];
   logic [crdp_pkg::LEN_W-1:0] rd_len_ff;
   logic [crdp_pkg::TAG_W-1:0] rd_tag_ff;

   // configuration
   logic [crdp_pkg::CNT_W-1:0]  max_entries_ff;
   logic [crdp_pkg::BYTE_W-1:0] max_bytes_ff;
   logic                        newest_ff;
   logic [crdp_pkg::CNT_W-1:0]  cap_entries;

   // latched request
   logic                        req_type_ff, req_type_in;
   logic [crdp_pkg::LEN_W-1:0]  req_len_ff, req_len_in;
   logic [crdp_pkg::TAG_W-1:0]  req_tag_ff, req_tag_in;

   // ring state
   logic [crdp_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [crdp_pkg::PTR_W-1:0]  tail_ff, tail_in;
   logic [crdp_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [crdp_pkg::BYTE_W-1:0] bytes_ff, bytes_in;
   logic [crdp_pkg::DROP_W-1:0] drops_ff, drops_in;
   logic [crdp_pkg::CNT_W-1:0]  peak_count_ff, peak_count_in;
   logic [crdp_pkg::BYTE_W-1:0] peak_bytes_ff, peak_bytes_in;
   logic [crdp_pkg::CNT_W-1:0]  evicted_ff, evicted_in;
   crdp_pkg::rsp_item_type      rsp_ff, rsp_in;

   logic [crdp_pkg::BYTE_W:0]   bytes_sum;

   always_comb begin
      if (max_entries_ff == '0) begin
         cap_entries = crdp_pkg::CNT_W'(1);
      end else if (max_entries_ff > crdp_pkg::CNT_W'(crdp_pkg::DEPTH)) begin
         cap_entries = crdp_pkg::CNT_W'(crdp_pkg::DEPTH);
      end else begin
         cap_entries = max_entries_ff;
      end
   end

   assign bytes_sum = {1'b0, bytes_ff} + (crdp_pkg::BYTE_W + 1)'(req_len_ff);

   always_comb begin
      stat.is_pop      = (req_type_ff == crdp_pkg::REQ_POP);
      stat.empty       = (count_ff == '0);
      stat.full        = (count_ff >= cap_entries);
      stat.over        = (bytes_sum > {1'b0, max_bytes_ff});
      stat.oversize    = (crdp_pkg::BYTE_W'(req_len_ff) > max_bytes_ff);
      stat.newest_mode = newest_ff;
      stat.evicted_any = (evicted_ff != '0);
   end

   always_comb begin
      req_type_in   = req_type_ff;
      req_len_in    = req_len_ff;
      req_tag_in    = req_tag_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      bytes_in      = bytes_ff;
      drops_in      = drops_ff;
      peak_count_in = peak_count_ff;
      peak_bytes_in = peak_bytes_ff;
      evicted_in    = evicted_ff;
      rsp_in        = rsp_ff;

      if (cmd.latch) begin
         req_type_in = req_item.req_type;
         req_len_in  = req_item.item_length;
         req_tag_in  = req_item.item_tag;
         evicted_in  = '0;
      end
      // head removal, shared by pop and eviction
      if (cmd.pop || cmd.evict) begin
         bytes_in = bytes_ff - crdp_pkg::BYTE_W'(rd_len_ff);
         head_in  = crdp_pkg::next_ptr(head_ff);
         count_in = count_ff - crdp_pkg::CNT_W'(1);
      end
      if (cmd.evict) begin
         evicted_in = evicted_ff + crdp_pkg::CNT_W'(1);
      end
      if (cmd.evict || cmd.drop) begin
         drops_in = drops_ff + crdp_pkg::DROP_W'(1);
      end
      if (cmd.store) begin
         tail_in  = crdp_pkg::next_ptr(tail_ff);
         count_in = count_ff + crdp_pkg::CNT_W'(1);
         bytes_in = bytes_sum[crdp_pkg::BYTE_W-1:0];
         if (count_in > peak_count_ff) begin
            peak_count_in = count_in;
         end
         if (bytes_in > peak_bytes_ff) begin
            peak_bytes_in = bytes_in;
         end
      end
      if (cmd.finish) begin
         rsp_in.status        = cmd.status;
         rsp_in.out_length    = cmd.pop ? rd_len_ff : '0;
         rsp_in.out_tag       = cmd.pop ? rd_tag_ff : '0;
         rsp_in.evicted_count = evicted_in;
         rsp_in.drop_total    = drops_in;
         rsp_in.occupancy     = count_in;
         rsp_in.bytes_held    = bytes_in;
         rsp_in.peak_entries  = peak_count_in;
         rsp_in.peak_bytes    = peak_bytes_in;
      end
   end

   // memories: written at the tail, read at the next head every cycle
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         length_mem[tail_ff] <= req_len_ff;
         tag_mem[tail_ff]    <= req_tag_ff;
      end
      rd_len_ff <= length_mem[head_in];
      rd_tag_ff <= tag_mem[head_in];
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      req_len_ff  <= req_len_in;
      req_tag_ff  <= req_tag_in;
      evicted_ff  <= evicted_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         bytes_ff       <= '0;
         drops_ff       <= '0;
         peak_count_ff  <= '0;
         peak_bytes_ff  <= '0;
         max_entries_ff <= crdp_pkg::MAX_ENTRIES_RST;
         max_bytes_ff   <= crdp_pkg::MAX_BYTES_RST;
         newest_ff      <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         bytes_ff      <= bytes_in;
         drops_ff      <= drops_in;
         peak_count_ff <= peak_count_in;
         peak_bytes_ff <= peak_bytes_in;
         if (csr_valid) begin
            case (csr_index)
               crdp_pkg::CSR_MAX_ENTRIES: max_entries_ff <= csr_data[crdp_pkg::CNT_W-1:0];
               crdp_pkg::CSR_MAX_BYTES:   max_bytes_ff   <= csr_data[crdp_pkg::BYTE_W-1:0];
               crdp_pkg::CSR_DROP_NEWEST: newest_ff      <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// File: rtl/capped_descriptor_ring_drop_policy_core.sv
// capped_descriptor_ring_drop_policy_core: top level of the capped descriptor ring
// depends on crdp_pkg, crdp_ctrl and crdp_datapath
//
//   channel   ports                                 handshake
//   request   start, busy, req_item                 taken when start && !busy
//   response  rsp_valid, rsp_item                   one-cycle strobe, no back-pressure
//   csr       csr_valid, csr_ready, csr_index/data  written when csr_valid && csr_ready
//
// a pop, a drop or a store without eviction is latched at accept, resolved in the
// check state and registered into the response strobe; a drop-oldest push first
// evicts head entries one at a time, as each check reads only the head of the memory
// busy falls in the cycle the response is shown, so the next transaction can follow
// synchronous reset clears pointers, the occupancy, byte and drop counters and the peaks and reloads the caps;
// descriptor memory is not cleared
// the receiver cannot stall: each response is presented for exactly one cycle
module capped_descriptor_ring_drop_policy_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  crdp_pkg::req_item_type             req_item,
   // response channel
   output logic                               rsp_valid,
   output crdp_pkg::rsp_item_type             rsp_item,
   // configuration channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [crdp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crdp_pkg::CSR_DAT_W-1:0]     csr_data
);

   crdp_pkg::ctl_cmd_type cmd;
   crdp_pkg::dp_stat_type stat;

   // registers accept a write every cycle; the user must write them only while idle, and the block does not enforce it
   assign csr_ready = 1'b1;

   // sequencing: idle, then check cycles until the transaction resolves
   crdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // ring storage, occupancy and byte accounting, result register
   crdp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTHESIS
   // the response strobe comes after the sequencer has returned to idle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // an accepted transaction always occupies the sequencer next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted transaction did not start");

   // one strobe per transaction, never two in a row
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("back-to-back response strobes");

   // high-water marks never trail the current fill
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.occupancy <= rsp_item.peak_entries &&
                     rsp_item.bytes_held <= rsp_item.peak_bytes))
      else $error("peak below current occupancy");
`endif

endmodule
